// ===== rtl/script_token_scanner_macros.svh =====
// Assertion helpers for the token scanner.
// Both use the clk and rst_n of the module that expands them.
`ifndef SCRIPT_TOKEN_SCANNER_MACROS_SVH
`define SCRIPT_TOKEN_SCANNER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("script_token_scanner: check failed");

// Consequent must hold in the cycle after the antecedent.
`define STSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("script_token_scanner: check failed");

`endif

// ===== rtl/stsc_pkg.sv =====
`default_nettype none

package stsc_pkg;

  localparam int TOKEN_BUFFER_SIZE = 4096;
  localparam int CHAR_W = 8;
  localparam int LINE_W = 20;
  localparam int CNT_W = 12;
  localparam int MAX_RES = 5;
  localparam int RES_IDX_W = $clog2(MAX_RES + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LINE_W-1:0] LINE_TOP = '1;
  localparam logic [CNT_W-1:0] LIMIT_MAX =
    CNT_W'((TOKEN_BUFFER_SIZE - 1 > 4095) ? 4095 : TOKEN_BUFFER_SIZE - 1);
  localparam logic [CNT_W-1:0] CFG_RESET = 12'd4095;

  localparam logic [CHAR_W-1:0] CH_LF = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'd34;
  localparam logic [CHAR_W-1:0] CH_STAR = 8'd42;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'd44;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'd47;
  localparam logic [CHAR_W-1:0] CH_SEMI = 8'd59;
  localparam logic [CHAR_W-1:0] CH_EQUAL = 8'd61;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'd91;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'd93;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'd123;
  localparam logic [CHAR_W-1:0] CH_BAR = 8'd124;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'd125;

  typedef enum logic [1:0] {
    KIND_CHAR       = 2'd0,
    KIND_END_TOKEN  = 2'd1,
    KIND_END_SCRIPT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    MODE_SKIP   = 3'd0,
    MODE_WORD   = 3'd1,
    MODE_QUOTED = 3'd2,
    MODE_LINE   = 3'd3,
    MODE_BLOCK  = 3'd4
  } mode_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] ch;
    logic [LINE_W-1:0] line;
    logic              crossed;
    logic              quoted;
  } result_t;

  typedef struct packed {
    result_t [MAX_RES-1:0] res;
    logic [RES_IDX_W-1:0]  n;
  } bundle_t;

  typedef struct packed {
    mode_t             mode;
    logic              slash;
    logic              star;
    logic [LINE_W-1:0] line;
    logic              crossed;
    logic [CNT_W-1:0]  cnt;
    logic              drop;
  } scan_st_t;

  localparam scan_st_t SCAN_RESET = '{
    mode: MODE_SKIP, slash: 1'b0, star: 1'b0, line: LINE_W'(1),
    crossed: 1'b0, cnt: '0, drop: 1'b0
  };

endpackage

`default_nettype wire

// ===== rtl/script_token_scanner.sv =====
// Script token scanner.
// Input queue port: drive in_script_byte / in_is_last_byte with push; a word
// is taken on a clock edge with push high and full low. Results come out as
// a queue: while empty is low the oldest result is on the out_ ports, and
// pop high takes it. cfg_we with cfg_max_token_chars sets the token length
// limit; write it only while no byte is in flight.
// Each accepted byte is scanned combinationally; its results (up to five),
// if any, go as one bundle into a four-entry queue. The output stage then
// drains a bundle one result per cycle while pop is high. The first result
// of a byte passes through the bundle queue and then the output register
// before it is on the out_ ports. Bytes are taken every cycle while the
// bundle queue has room; a byte with k results needs k pops at the output,
// so sustained rate is set by the result count per byte.
// When pop stays low the output holds, the queue fills and full rises;
// scanning resumes as soon as a bundle drains.
// Reset: line 1, between tokens, limit 4095, both queues empty.
`default_nettype none

`include "script_token_scanner_macros.svh"

module script_token_scanner import stsc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CNT_W-1:0]  cfg_max_token_chars,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [CHAR_W-1:0] in_script_byte,
  input  wire logic              in_is_last_byte,
  output logic                   empty,
  input  wire logic              pop,
  output logic [1:0]             out_item_kind,
  output logic [CHAR_W-1:0]      out_token_char,
  output logic [LINE_W-1:0]      out_line_number,
  output logic                   out_newline_before,
  output logic                   out_was_quoted,
  output logic                   out_last_of_run
);

  logic    accept;
  logic    q_push;
  bundle_t f_bundle;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;
  bundle_t q_head;
  result_t res;

  assign full = q_full;
  assign accept = push && !q_full;

  stsc_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_max_token_chars (cfg_max_token_chars),
    .accept              (accept),
    .script_byte         (in_script_byte),
    .is_last_byte        (in_is_last_byte),
    .q_push              (q_push),
    .q_bundle            (f_bundle)
  );

  stsc_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (q_push),
    .push_bundle (f_bundle),
    .full        (q_full),
    .pop         (q_pop),
    .head        (q_head),
    .empty       (q_empty)
  );

  stsc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .res         (res),
    .last_of_run (out_last_of_run)
  );

  assign out_item_kind = res.kind;
  assign out_token_char = res.ch;
  assign out_line_number = res.line;
  assign out_newline_before = res.crossed;
  assign out_was_quoted = res.quoted;

  `STSC_ASSERT_NOW(a_bundle_not_empty, q_push, (f_bundle.n != '0) && (f_bundle.n <= RES_IDX_W'(MAX_RES)))
  `STSC_ASSERT_NOW(a_eos_ends_run, !empty && (res.kind == KIND_END_SCRIPT), out_last_of_run)
  `STSC_ASSERT_NEXT(a_drain_goes_empty, pop && !empty && out_last_of_run && q_empty, empty)

endmodule

`default_nettype wire

// ===== rtl/stsc_front.sv =====
`default_nettype none

module stsc_front import stsc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CNT_W-1:0]  cfg_max_token_chars,
  input  wire logic              accept,
  input  wire logic [CHAR_W-1:0] script_byte,
  input  wire logic              is_last_byte,
  output logic                   q_push,
  output bundle_t                q_bundle
);

  typedef struct packed {
    scan_st_t st;
    bundle_t  bd;
  } work_t;

  logic [CNT_W-1:0] mtc_r;
  logic [CNT_W-1:0] lim;
  scan_st_t         st_r;
  scan_st_t         st_nxt;
  work_t            w;

  function automatic logic f_is_punct(logic [CHAR_W-1:0] b);
    return b inside {CH_LBRACE, CH_RBRACE, CH_BAR, CH_EQUAL, CH_COMMA, CH_LBRACK, CH_RBRACK};
  endfunction

  function automatic work_t f_emit(work_t wi, kind_t k, logic [CHAR_W-1:0] ch, logic q);
    work_t r;
    r = wi;
    if (r.bd.n < RES_IDX_W'(MAX_RES)) begin
      r.bd.res[r.bd.n[RES_IDX_W-1:0]] = '{kind: k, ch: ch, line: r.st.line,
                                          crossed: r.st.crossed, quoted: q};
      r.bd.n = r.bd.n + RES_IDX_W'(1);
    end
    return r;
  endfunction

  function automatic work_t f_end_token(work_t wi, logic q);
    work_t r;
    r = f_emit(wi, KIND_END_TOKEN, '0, q);
    r.st.crossed = 1'b0;
    return r;
  endfunction

  function automatic work_t f_new_line(work_t wi);
    work_t r;
    r = wi;
    if (r.st.line != LINE_TOP) begin
      r.st.line = r.st.line + LINE_W'(1);
    end
    r.st.crossed = 1'b1;
    return r;
  endfunction

  function automatic work_t f_word_char(work_t wi, logic [CHAR_W-1:0] b,
                                        logic [CNT_W-1:0] l);
    work_t r;
    r = wi;
    if (r.st.mode != MODE_WORD) begin
      r.st.mode = MODE_WORD;
      r.st.cnt = '0;
    end
    r = f_emit(r, KIND_CHAR, b, 1'b0);
    r.st.cnt = r.st.cnt + CNT_W'(1);
    if (r.st.cnt >= l) begin
      r = f_end_token(r, 1'b0);
      r.st.mode = MODE_SKIP;
      r.st.cnt = '0;
    end
    return r;
  endfunction

  function automatic work_t f_skip_byte(work_t wi, logic [CHAR_W-1:0] b, logic last,
                                        logic [CNT_W-1:0] l);
    work_t r;
    r = wi;
    if (b <= CH_SPACE) begin
      if (b == CH_LF) begin
        r = f_new_line(r);
      end
    end else if (b == CH_SEMI) begin
      r.st.mode = MODE_LINE;
    end else if (b == CH_SLASH) begin
      if (last) begin
        r = f_word_char(r, b, l);
      end else begin
        r.st.slash = 1'b1;
      end
    end else if (f_is_punct(b)) begin
      r = f_emit(r, KIND_CHAR, b, 1'b0);
      r = f_end_token(r, 1'b0);
    end else if (b == CH_QUOTE) begin
      r.st.mode = MODE_QUOTED;
      r.st.cnt = '0;
    end else begin
      r = f_word_char(r, b, l);
    end
    return r;
  endfunction

  always_comb begin
    if (mtc_r == '0) begin
      lim = CNT_W'(1);
    end else if (mtc_r > LIMIT_MAX) begin
      lim = LIMIT_MAX;
    end else begin
      lim = mtc_r;
    end
  end

  // Scan one byte: next scan state and the results it causes.
  always_comb begin
    logic handled;
    handled = 1'b0;
    w.st = st_r;
    w.bd = '0;
    if (w.st.drop) begin
      w.st.drop = 1'b0;
    end else begin
      if (w.st.slash) begin
        w.st.slash = 1'b0;
        if (script_byte == CH_SLASH || script_byte == CH_STAR) begin
          if (w.st.mode == MODE_WORD) begin
            w = f_end_token(w, 1'b0);
          end
          w.st.cnt = '0;
          w.st.mode = (script_byte == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
          w.st.star = 1'b0;
          handled = 1'b1;
        end else begin
          w = f_word_char(w, CH_SLASH, lim);
        end
      end
      if (!handled) begin
        case (w.st.mode)
          MODE_WORD: begin
            if (script_byte <= CH_SPACE || script_byte == CH_SEMI || f_is_punct(script_byte))
            begin
              w = f_end_token(w, 1'b0);
              w.st.mode = MODE_SKIP;
              w.st.cnt = '0;
              w = f_skip_byte(w, script_byte, is_last_byte, lim);
            end else if (script_byte == CH_SLASH && !is_last_byte) begin
              w.st.slash = 1'b1;
            end else begin
              w = f_word_char(w, script_byte, lim);
            end
          end
          MODE_QUOTED: begin
            if (script_byte == CH_QUOTE) begin
              w = f_end_token(w, 1'b1);
              w.st.mode = MODE_SKIP;
              w.st.cnt = '0;
            end else begin
              w = f_emit(w, KIND_CHAR, script_byte, 1'b1);
              w.st.cnt = w.st.cnt + CNT_W'(1);
              if (w.st.cnt >= lim) begin
                w = f_end_token(w, 1'b1);
                w.st.mode = MODE_SKIP;
                w.st.cnt = '0;
                w.st.drop = 1'b1;
              end
            end
          end
          MODE_LINE: begin
            if (script_byte == CH_LF) begin
              w = f_new_line(w);
              w.st.mode = MODE_SKIP;
            end
          end
          MODE_BLOCK: begin
            if (script_byte == CH_LF) begin
              w = f_new_line(w);
            end
            if (w.st.star && script_byte == CH_SLASH) begin
              w.st.mode = MODE_SKIP;
              w.st.star = 1'b0;
            end else begin
              w.st.star = (script_byte == CH_STAR);
            end
          end
          default: begin
            w.st.mode = MODE_SKIP;
            w = f_skip_byte(w, script_byte, is_last_byte, lim);
          end
        endcase
      end
    end
    if (is_last_byte) begin
      if (w.st.mode == MODE_WORD) begin
        w = f_end_token(w, 1'b0);
      end else if (w.st.mode == MODE_QUOTED) begin
        w = f_end_token(w, 1'b1);
      end
      w = f_emit(w, KIND_END_SCRIPT, '0, 1'b0);
      w.st = SCAN_RESET;
    end
  end

  always_comb begin
    st_nxt = accept ? w.st : st_r;
  end

  always_comb begin
    q_push = accept && (w.bd.n != '0);
    q_bundle = w.bd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SCAN_RESET;
      mtc_r <= CFG_RESET;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        mtc_r <= cfg_max_token_chars;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/stsc_queue.sv =====
`default_nettype none

module stsc_queue import stsc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire bundle_t push_bundle,
  output logic         full,
  input  wire logic    pop,
  output bundle_t      head,
  output logic         empty
);

  bundle_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_r;
  logic [QPTR_W-1:0]  wr_nxt;
  logic [QPTR_W-1:0]  rd_r;
  logic [QPTR_W-1:0]  rd_nxt;
  logic [QCNT_W-1:0]  cnt_r;
  logic [QCNT_W-1:0]  cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign full = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_comb begin
    wr_nxt = do_push ? QPTR_W'((32'(wr_r) + 1) % QUEUE_DEPTH) : wr_r;
    rd_nxt = do_pop ? QPTR_W'((32'(rd_r) + 1) % QUEUE_DEPTH) : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_bundle;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/stsc_back.sv =====
`default_nettype none

module stsc_back import stsc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    q_empty,
  input  wire bundle_t q_head,
  output logic         q_pop,
  output logic         empty,
  input  wire logic    pop,
  output result_t      res,
  output logic         last_of_run
);

  bundle_t               cur_r;
  bundle_t               cur_nxt;
  logic                  valid_r;
  logic                  valid_nxt;
  logic [RES_IDX_W-1:0]  idx_r;
  logic [RES_IDX_W-1:0]  idx_nxt;
  logic                  take;
  logic                  done;

  assign empty = !valid_r;
  assign res = cur_r.res[idx_r];
  assign last_of_run = (idx_r == cur_r.n - RES_IDX_W'(1));
  assign take = valid_r && pop;
  assign done = take && last_of_run;
  assign q_pop = (!valid_r || done) && !q_empty;

  always_comb begin
    cur_nxt = q_pop ? q_head : cur_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
      idx_nxt = '0;
    end else if (done) begin
      valid_nxt = 1'b0;
      idx_nxt = '0;
    end else begin
      valid_nxt = valid_r;
      idx_nxt = take ? idx_r + RES_IDX_W'(1) : idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

`default_nettype wire
